### sv/sbct_pkg.sv
// Shared constants and types of the segment box clearance test unit.
package sbct_pkg;

   localparam int COORD_BITS     = 32;
   localparam int TIME_FRAC_BITS = 16;

   // Clearance register keeps the low COORD_BITS-1 bits.
   localparam int CLR_BITS   = COORD_BITS - 1;
   // Expanded bounds, slab numerators and deltas never exceed this signed width.
   localparam int EXT_BITS   = COORD_BITS + 2;
   // Magnitudes of numerators and all denominators.
   localparam int MAG_BITS   = COORD_BITS + 1;
   // The shared multiplier takes one operand in two slices.
   localparam int SLICE_BITS = (MAG_BITS + 1) / 2;
   localparam int PROD_BITS  = MAG_BITS + SLICE_BITS;
   // Holds the difference of two full cross products.
   localparam int ACC_BITS   = 2 * MAG_BITS + 1;
   localparam int TIME_BITS  = TIME_FRAC_BITS + 1;
   localparam int QCNT_BITS  = $clog2(TIME_BITS);
   localparam int PHASE_BITS = 2;

   localparam logic [TIME_BITS-1:0]  TIME_ONE   = TIME_BITS'(1) << TIME_FRAC_BITS;
   localparam logic [PHASE_BITS-1:0] PHASE_LAST = '1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EXT_BITS-1:0]   ext_type;
   typedef logic [MAG_BITS-1:0]          mag_type;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_EXPAND = 8'b0000_0010,
      S_AXIS   = 8'b0000_0100,
      S_LOAD   = 8'b0000_1000,
      S_MUL    = 8'b0001_0000,
      S_RES    = 8'b0010_0000,
      S_QUANT  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   // Which fraction comparison the shared unit is working on.
   typedef enum logic [1:0] {
      CMP_ENTRY,
      CMP_EXIT,
      CMP_ORDER
   } cmp_type;

endpackage

### sv/segment_box_clearance_test_unit.sv
// Segment versus clearance-expanded box slab test with a shared cross-product unit.
//
// Usage: each transfer on the req_ channel brings one segment and one box of a run;
// req_last_box marks the final box of the run. For every input transfer exactly one
// result transfer appears on the rsp_ channel, in order. The clearance register is
// written through csr_wr_en / csr_wr_data; the user must write it only while the
// block is idle, as the block itself does not enforce this. It takes effect for the
// next box.
// A box with min above max on an axis goes from the expansion step straight to
// its result. An axis with zero delta takes the expand and axis steps; an axis
// with nonzero delta adds three exact fraction comparisons, each a load of the
// operands, the half products and a resolve. A hit then forms the entry time in
// the divider, one quotient bit per cycle. The steps and their order are set by
// the single 33x17 multiplier with its accumulator, which forms each cross
// product in two halves, and by the restoring divider.
// req_stall is high whenever an item is in progress. A finished result sits in an
// output register; the block accepts the next item while it waits, and only holds
// before writing a new result when the old one is still stalled.
// Reset clears the sequencer, the result valid flag, the run any-hit state and the
// clearance register.
module segment_box_clearance_test_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sbct_pkg::CLR_BITS-1:0]       csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sbct_pkg::COORD_BITS-1:0] req_start_x,
   input  logic signed [sbct_pkg::COORD_BITS-1:0] req_start_y,
   input  logic signed [sbct_pkg::COORD_BITS-1:0] req_end_x,
   input  logic signed [sbct_pkg::COORD_BITS-1:0] req_end_y,
   input  logic signed [sbct_pkg::COORD_BITS-1:0] req_box_min_x,
   input  logic signed [sbct_pkg::COORD_BITS-1:0] req_box_min_y,
   input  logic signed [sbct_pkg::COORD_BITS-1:0] req_box_max_x,
   input  logic signed [sbct_pkg::COORD_BITS-1:0] req_box_max_y,
   input  logic                                req_last_box,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_box_hit,
   output logic [sbct_pkg::TIME_BITS-1:0]      rsp_entry_time,
   output logic                                rsp_box_invalid,
   output logic                                rsp_any_hit,
   output logic                                rsp_run_done
);
   import sbct_pkg::*;

   // Sequencer state.
   state_type              state_ff, state_in;
   logic                   axis_ff, axis_in;
   cmp_type                cmp_sel_ff, cmp_sel_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [QCNT_BITS-1:0]   qcnt_ff, qcnt_in;

   // Captured item and configuration.
   coord_type              sx_ff, sy_ff, ex_ff, ey_ff;
   coord_type              mnx_ff, mny_ff, mxx_ff, mxy_ff;
   logic                   last_ff;
   logic [CLR_BITS-1:0]    clearance_ff;

   // Slab working values. Times are kept as exact fractions n/d with d > 0.
   ext_type                lo_ff, lo_in, hi_ff, hi_in, delta_ff, delta_in;
   ext_type                cand_en_ff, cand_en_in, cand_xn_ff, cand_xn_in;
   mag_type                cand_d_ff, cand_d_in;
   ext_type                t_en_ff, t_en_in, t_xn_ff, t_xn_in;
   mag_type                t_ed_ff, t_ed_in, t_xd_ff, t_xd_in;

   // Operands of the shared cross-product compare.
   mag_type                mag_a_ff, mag_a_in, mag_c_ff, mag_c_in;
   mag_type                den_a_ff, den_a_in, den_c_ff, den_c_in;
   logic                   neg_a_ff, neg_a_in, neg_c_ff, neg_c_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;

   // Entry time divider.
   logic [EXT_BITS-1:0]    rem_ff, rem_in;
   logic [TIME_BITS-1:0]   q_ff, q_in;

   logic                   res_hit_ff, res_hit_in, res_inv_ff, res_inv_in;
   logic                   any_acc_ff, any_acc_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_hit_ff, out_hit_in, out_inv_ff, out_inv_in;
   logic                   out_any_ff, out_any_in, out_done_ff, out_done_in;
   logic [TIME_BITS-1:0]   out_entry_ff, out_entry_in;

   // Per-axis operand selection.
   coord_type              o_sel, e_sel, mn_sel, mx_sel;
   ext_type                o_ext, an_sel, cn_sel;
   mag_type                ad_sel, cd_sel;

   // Shared multiplier datapath.
   mag_type                mul_a, den_sel;
   logic [SLICE_BITS-1:0]  slice;
   logic [PROD_BITS-1:0]   prod;
   logic [ACC_BITS-1:0]    term;

   // Compare and divider outcomes.
   logic                   acc_neg, acc_pos, a_gt, a_lt;
   logic [EXT_BITS-1:0]    shift_r;
   logic                   q_ge;
   logic                   box_bad, in_slab, delta_neg;
   logic                   req_xfer, rsp_free;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      o_sel  = axis_ff ? sy_ff  : sx_ff;
      e_sel  = axis_ff ? ey_ff  : ex_ff;
      mn_sel = axis_ff ? mny_ff : mnx_ff;
      mx_sel = axis_ff ? mxy_ff : mxx_ff;
   end

   assign o_ext     = EXT_BITS'(o_sel);
   assign box_bad   = (mnx_ff > mxx_ff) || (mny_ff > mxy_ff);
   assign in_slab   = (lo_ff <= o_ext) && (o_ext <= hi_ff);
   assign delta_neg = delta_ff[EXT_BITS-1];

   // Fraction pair for the comparison at hand: a = an/ad against c = cn/cd.
   always_comb begin
      case (cmp_sel_ff)
         CMP_ENTRY: begin
            an_sel = cand_en_ff;
            ad_sel = cand_d_ff;
            cn_sel = t_en_ff;
            cd_sel = t_ed_ff;
         end
         CMP_EXIT: begin
            an_sel = cand_xn_ff;
            ad_sel = cand_d_ff;
            cn_sel = t_xn_ff;
            cd_sel = t_xd_ff;
         end
         CMP_ORDER: begin
            an_sel = t_en_ff;
            ad_sel = t_ed_ff;
            cn_sel = t_xn_ff;
            cd_sel = t_xd_ff;
         end
         default: begin
            an_sel = t_en_ff;
            ad_sel = t_ed_ff;
            cn_sel = t_xn_ff;
            cd_sel = t_xd_ff;
         end
      endcase
   end

   // The accumulator forms |an|*cd - |cn|*ad in four half products.
   always_comb begin
      mul_a   = phase_ff[1] ? mag_c_ff : mag_a_ff;
      den_sel = phase_ff[1] ? den_a_ff : den_c_ff;
      slice   = phase_ff[0] ? SLICE_BITS'(den_sel >> SLICE_BITS)
                            : den_sel[SLICE_BITS-1:0];
      prod    = PROD_BITS'(mul_a) * PROD_BITS'(slice);
      term    = phase_ff[0] ? (ACC_BITS'(prod) << SLICE_BITS) : ACC_BITS'(prod);
   end

   always_comb begin
      acc_neg = acc_ff[ACC_BITS-1];
      acc_pos = !acc_neg && (|acc_ff);
      if (neg_a_ff != neg_c_ff) begin
         a_gt = !neg_a_ff;
         a_lt = neg_a_ff;
      end else begin
         // Both negative: larger magnitude means the smaller value.
         a_gt = neg_a_ff ? acc_neg : acc_pos;
         a_lt = neg_a_ff ? acc_pos : acc_neg;
      end
   end

   assign shift_r = (qcnt_ff == '0) ? rem_ff : (rem_ff << 1);
   assign q_ge    = shift_r >= EXT_BITS'(t_ed_ff);

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cmp_sel_in   = cmp_sel_ff;
      phase_in     = phase_ff;
      qcnt_in      = qcnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      delta_in     = delta_ff;
      cand_en_in   = cand_en_ff;
      cand_xn_in   = cand_xn_ff;
      cand_d_in    = cand_d_ff;
      t_en_in      = t_en_ff;
      t_ed_in      = t_ed_ff;
      t_xn_in      = t_xn_ff;
      t_xd_in      = t_xd_ff;
      mag_a_in     = mag_a_ff;
      mag_c_in     = mag_c_ff;
      den_a_in     = den_a_ff;
      den_c_in     = den_c_ff;
      neg_a_in     = neg_a_ff;
      neg_c_in     = neg_c_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      res_hit_in   = res_hit_ff;
      res_inv_in   = res_inv_ff;
      any_acc_in   = any_acc_ff;
      rsp_valid_in = rsp_valid_ff;
      out_hit_in   = out_hit_ff;
      out_inv_in   = out_inv_ff;
      out_any_in   = out_any_ff;
      out_done_in  = out_done_ff;
      out_entry_in = out_entry_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               axis_in    = 1'b0;
               t_en_in    = '0;
               t_ed_in    = MAG_BITS'(1);
               t_xn_in    = EXT_BITS'(1);
               t_xd_in    = MAG_BITS'(1);
               q_in       = '0;
               res_hit_in = 1'b0;
               res_inv_in = 1'b0;
               state_in   = S_EXPAND;
            end
         end
         S_EXPAND: begin
            lo_in    = EXT_BITS'(mn_sel) - $signed(EXT_BITS'(clearance_ff));
            hi_in    = EXT_BITS'(mx_sel) + $signed(EXT_BITS'(clearance_ff));
            delta_in = EXT_BITS'(e_sel) - o_ext;
            if (!axis_ff && box_bad) begin
               res_inv_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_AXIS;
            end
         end
         S_AXIS: begin
            if (delta_ff == '0) begin
               if (!in_slab) begin
                  state_in = S_DONE;
               end else if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = S_EXPAND;
               end else begin
                  rem_in   = t_en_ff;
                  qcnt_in  = '0;
                  state_in = S_QUANT;
               end
            end else begin
               if (delta_neg) begin
                  cand_en_in = o_ext - hi_ff;
                  cand_xn_in = o_ext - lo_ff;
                  cand_d_in  = MAG_BITS'(-delta_ff);
               end else begin
                  cand_en_in = lo_ff - o_ext;
                  cand_xn_in = hi_ff - o_ext;
                  cand_d_in  = MAG_BITS'(delta_ff);
               end
               cmp_sel_in = CMP_ENTRY;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            neg_a_in = an_sel[EXT_BITS-1];
            neg_c_in = cn_sel[EXT_BITS-1];
            mag_a_in = MAG_BITS'(an_sel[EXT_BITS-1] ? -an_sel : an_sel);
            mag_c_in = MAG_BITS'(cn_sel[EXT_BITS-1] ? -cn_sel : cn_sel);
            den_a_in = ad_sel;
            den_c_in = cd_sel;
            phase_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            case (phase_ff[1])
               1'b0:    acc_in = phase_ff[0] ? (acc_ff + term) : term;
               1'b1:    acc_in = acc_ff - term;
               default: acc_in = acc_ff;
            endcase
            phase_in = phase_ff + PHASE_BITS'(1);
            if (phase_ff == PHASE_LAST) begin
               state_in = S_RES;
            end
         end
         S_RES: begin
            case (cmp_sel_ff)
               CMP_ENTRY: begin
                  if (a_gt) begin
                     t_en_in = cand_en_ff;
                     t_ed_in = cand_d_ff;
                  end
                  cmp_sel_in = CMP_EXIT;
                  state_in   = S_LOAD;
               end
               CMP_EXIT: begin
                  if (a_lt) begin
                     t_xn_in = cand_xn_ff;
                     t_xd_in = cand_d_ff;
                  end
                  cmp_sel_in = CMP_ORDER;
                  state_in   = S_LOAD;
               end
               default: begin
                  // Entry not after exit, a tie counts as a hit.
                  if (a_gt) begin
                     state_in = S_DONE;
                  end else if (!axis_ff) begin
                     axis_in  = 1'b1;
                     state_in = S_EXPAND;
                  end else begin
                     rem_in   = t_en_ff;
                     qcnt_in  = '0;
                     state_in = S_QUANT;
                  end
               end
            endcase
         end
         S_QUANT: begin
            rem_in  = q_ge ? (shift_r - EXT_BITS'(t_ed_ff)) : shift_r;
            q_in    = {q_ff[TIME_BITS-2:0], q_ge};
            qcnt_in = qcnt_ff + QCNT_BITS'(1);
            if (qcnt_ff == QCNT_BITS'(TIME_BITS - 1)) begin
               res_hit_in = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_hit_in   = res_hit_ff;
               out_inv_in   = res_inv_ff;
               out_entry_in = q_ff;
               out_any_in   = any_acc_ff || res_hit_ff || res_inv_ff;
               out_done_in  = last_ff;
               any_acc_in   = last_ff ? 1'b0 : (any_acc_ff || res_hit_ff || res_inv_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         any_acc_ff   <= 1'b0;
         clearance_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         any_acc_ff   <= any_acc_in;
         if (csr_wr_en) begin
            clearance_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sx_ff   <= req_start_x;
         sy_ff   <= req_start_y;
         ex_ff   <= req_end_x;
         ey_ff   <= req_end_y;
         mnx_ff  <= req_box_min_x;
         mny_ff  <= req_box_min_y;
         mxx_ff  <= req_box_max_x;
         mxy_ff  <= req_box_max_y;
         last_ff <= req_last_box;
      end
      axis_ff      <= axis_in;
      cmp_sel_ff   <= cmp_sel_in;
      phase_ff     <= phase_in;
      qcnt_ff      <= qcnt_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      delta_ff     <= delta_in;
      cand_en_ff   <= cand_en_in;
      cand_xn_ff   <= cand_xn_in;
      cand_d_ff    <= cand_d_in;
      t_en_ff      <= t_en_in;
      t_ed_ff      <= t_ed_in;
      t_xn_ff      <= t_xn_in;
      t_xd_ff      <= t_xd_in;
      mag_a_ff     <= mag_a_in;
      mag_c_ff     <= mag_c_in;
      den_a_ff     <= den_a_in;
      den_c_ff     <= den_c_in;
      neg_a_ff     <= neg_a_in;
      neg_c_ff     <= neg_c_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      res_hit_ff   <= res_hit_in;
      res_inv_ff   <= res_inv_in;
      out_hit_ff   <= out_hit_in;
      out_inv_ff   <= out_inv_in;
      out_any_ff   <= out_any_in;
      out_done_ff  <= out_done_in;
      out_entry_ff <= out_entry_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_hit     = out_hit_ff;
   assign rsp_entry_time  = out_entry_ff;
   assign rsp_box_invalid = out_inv_ff;
   assign rsp_any_hit     = out_any_ff;
   assign rsp_run_done    = out_done_ff;

   // The four half products always complete before a comparison is resolved.
   a_mul_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && phase_ff == PHASE_LAST) |=> (state_ff == S_RES))
      else $error("cross product sequence did not end in resolve");

   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_box_hit && rsp_box_invalid))
      else $error("hit reported on an invalid box");

   a_entry_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_box_hit) |-> (rsp_entry_time == '0))
      else $error("entry time nonzero without a hit");

   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_time <= TIME_ONE))
      else $error("entry time beyond one");

   a_any_cover: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_box_hit || rsp_box_invalid)) |-> rsp_any_hit)
      else $error("any-hit misses the current box");

endmodule

### verif/sbct_checker.sv
// Result checker for the segment box clearance test unit: predicts each result and compares it.
module sbct_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [sbct_pkg::CLR_BITS-1:0]     csr_wr_data,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  sbct_pkg::coord_type               req_start_x,
   input  sbct_pkg::coord_type               req_start_y,
   input  sbct_pkg::coord_type               req_end_x,
   input  sbct_pkg::coord_type               req_end_y,
   input  sbct_pkg::coord_type               req_box_min_x,
   input  sbct_pkg::coord_type               req_box_min_y,
   input  sbct_pkg::coord_type               req_box_max_x,
   input  sbct_pkg::coord_type               req_box_max_y,
   input  logic                              req_last_box,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_box_hit,
   input  logic [sbct_pkg::TIME_BITS-1:0]    rsp_entry_time,
   input  logic                              rsp_box_invalid,
   input  logic                              rsp_any_hit,
   input  logic                              rsp_run_done,
   output int                                errors,
   output int                                pending
);
   import sbct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                 box_hit;
      logic [TIME_BITS-1:0] entry_time;
      logic                 box_invalid;
      logic                 any_hit;
      logic                 run_done;
   } box_outcome_type;

   // An exact segment parameter num/den; den is always positive.
   typedef struct packed {
      logic signed [63:0] num;
      logic signed [63:0] den;
   } ratio_type;

   box_outcome_type     outcome_q[$];
   logic [CLR_BITS-1:0] margin;
   logic                run_any_hit;

   // Cross-multiplied compare of two ratios: -1, 0 or 1.
   function automatic int ratio_cmp(input ratio_type a, input ratio_type b);
      logic signed [127:0] lhs;
      logic signed [127:0] rhs;
      lhs = 128'(a.num) * 128'(b.den);
      rhs = 128'(b.num) * 128'(a.den);
      if (lhs < rhs) return -1;
      if (lhs > rhs) return 1;
      return 0;
   endfunction

   // One slab of the clip; narrows the entry/exit window and says if it is still open.
   function automatic bit clip_slab(input longint o, input longint e, input longint lo,
                                    input longint hi, inout ratio_type t_in,
                                    inout ratio_type t_out);
      longint    span;
      ratio_type near;
      ratio_type far;
      span = e - o;
      if (span == 0) return (lo <= o) && (o <= hi);
      if (span > 0) begin
         near = '{lo - o, span};
         far  = '{hi - o, span};
      end else begin
         near = '{o - hi, -span};
         far  = '{o - lo, -span};
      end
      if (ratio_cmp(near, t_in) > 0) t_in = near;
      if (ratio_cmp(far, t_out) < 0) t_out = far;
      return ratio_cmp(t_in, t_out) <= 0;
   endfunction

   // Hit, entry time and validity of one box; the run fields are filled in by the caller.
   function automatic box_outcome_type judge_box(input coord_type sx, input coord_type sy,
                                                 input coord_type ex, input coord_type ey,
                                                 input coord_type mnx, input coord_type mny,
                                                 input coord_type mxx, input coord_type mxy,
                                                 input logic [CLR_BITS-1:0] grow);
      box_outcome_type v;
      ratio_type       t_in;
      ratio_type       t_out;
      longint          c;
      longint          q;
      v = '0;
      c = longint'(grow);
      if (mnx > mxx || mny > mxy) begin
         v.box_invalid = 1'b1;
      end else begin
         t_in  = '{64'sd0, 64'sd1};
         t_out = '{64'sd1, 64'sd1};
         if (clip_slab(longint'(sx), longint'(ex), longint'(mnx) - c, longint'(mxx) + c,
                       t_in, t_out) &&
             clip_slab(longint'(sy), longint'(ey), longint'(mny) - c, longint'(mxy) + c,
                       t_in, t_out)) begin
            v.box_hit = 1'b1;
            q = (t_in.num << TIME_FRAC_BITS) / t_in.den;
            v.entry_time = TIME_BITS'(q);
         end
      end
      return v;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t: rsp_%s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      box_outcome_type want;
      if (reset) begin
         outcome_q.delete();
         margin      = '0;
         run_any_hit = 1'b0;
         errors      = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: result transfer with no result expected", $time);
            end else begin
               want = outcome_q.pop_front();
               check_field("box_hit", want.box_hit, rsp_box_hit);
               check_field("entry_time", want.entry_time, rsp_entry_time);
               check_field("box_invalid", want.box_invalid, rsp_box_invalid);
               check_field("any_hit", want.any_hit, rsp_any_hit);
               check_field("run_done", want.run_done, rsp_run_done);
            end
         end
         if (req_valid && !req_stall) begin
            want = judge_box(req_start_x, req_start_y, req_end_x, req_end_y,
                             req_box_min_x, req_box_min_y, req_box_max_x, req_box_max_y,
                             margin);
            run_any_hit   = run_any_hit | want.box_hit | want.box_invalid;
            want.any_hit  = run_any_hit;
            want.run_done = req_last_box;
            if (req_last_box) run_any_hit = 1'b0;
            outcome_q.insert(outcome_q.size(), want);
         end
         if (csr_wr_en) margin = csr_wr_data;
      end
      pending = outcome_q.size();
   end

endmodule

### verif/tb.sv
// Top level of the segment box clearance test unit testbench: stimulus and verdict.
module tb;
   import sbct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Q16.16 landmarks used by the directed boxes.
   localparam coord_type FX_ONE  = 32'sh0001_0000;
   localparam coord_type FX_HALF = 32'sh0000_8000;
   localparam coord_type C_MIN   = 32'sh8000_0000;
   localparam coord_type C_MAX   = 32'sh7FFF_FFFF;
   localparam logic [CLR_BITS-1:0] CLR_MAX = '1;

   // Random part: several clearance settings, each with its own block of boxes.
   localparam int PHASES       = 8;
   localparam int PHASE_BOXES  = 216;
   // The slowest box, the longest sender gap and a usual receiver stall run are all
   // far shorter than this, so this many quiet cycles means a hang.
   localparam int QUIET_LIMIT  = 5000;
   // Cycles to keep watching for stray results once everything has come back.
   localparam int SETTLE_TIME  = 60;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  csr_wr_en     = 1'b0;
   logic [CLR_BITS-1:0]   csr_wr_data   = '0;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   coord_type             req_start_x   = '0;
   coord_type             req_start_y   = '0;
   coord_type             req_end_x     = '0;
   coord_type             req_end_y     = '0;
   coord_type             req_box_min_x = '0;
   coord_type             req_box_min_y = '0;
   coord_type             req_box_max_x = '0;
   coord_type             req_box_max_y = '0;
   logic                  req_last_box  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic                  rsp_box_hit;
   logic [TIME_BITS-1:0]  rsp_entry_time;
   logic                  rsp_box_invalid;
   logic                  rsp_any_hit;
   logic                  rsp_run_done;

   int                    errors;
   int                    pending;
   int                    quiet_cycles  = 0;
   logic [CLR_BITS-1:0]   cur_clearance = '0;
   stall_mode_type        stall_mode    = STALL_NONE;
   int                    stall_window  = 0;

   always #10 clock = ~clock;

   segment_box_clearance_test_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_box_min_x   (req_box_min_x),
      .req_box_min_y   (req_box_min_y),
      .req_box_max_x   (req_box_max_x),
      .req_box_max_y   (req_box_max_y),
      .req_last_box    (req_last_box),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_box_hit     (rsp_box_hit),
      .rsp_entry_time  (rsp_entry_time),
      .rsp_box_invalid (rsp_box_invalid),
      .rsp_any_hit     (rsp_any_hit),
      .rsp_run_done    (rsp_run_done)
   );

   sbct_checker outcome_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_box_min_x   (req_box_min_x),
      .req_box_min_y   (req_box_min_y),
      .req_box_max_x   (req_box_max_x),
      .req_box_max_y   (req_box_max_y),
      .req_last_box    (req_last_box),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_box_hit     (rsp_box_hit),
      .rsp_entry_time  (rsp_entry_time),
      .rsp_box_invalid (rsp_box_invalid),
      .rsp_any_hit     (rsp_any_hit),
      .rsp_run_done    (rsp_run_done),
      .errors          (errors),
      .pending         (pending)
   );

   // The receiver switches between stall modes in windows of random length, so that
   // there are stretches with no stall at all, light and heavy random stalling, and
   // a regular on/off pattern that beats against the block's own timing.
   always @(negedge clock) begin
      if (stall_window == 0) begin
         stall_mode   <= stall_mode_type'($urandom_range(3, 0));
         stall_window <= $urandom_range(300, 40);
      end else begin
         stall_window <= stall_window - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(3, 0) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(3, 0) != 0);
         STALL_PERIODIC: rsp_stall <= ((stall_window % 7) < 4);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   // Watchdog: a run of cycles with no transfer on either channel means the block hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offers one box at the current falling edge and holds it until it is taken.
   // It returns at the falling edge after the transfer, with valid still high, so
   // that the caller either offers the next box or lowers valid there.
   task automatic send_box(input coord_type sx, input coord_type sy,
                           input coord_type ex, input coord_type ey,
                           input coord_type mnx, input coord_type mny,
                           input coord_type mxx, input coord_type mxy, input bit last);
      req_valid     <= 1'b1;
      req_start_x   <= sx;
      req_start_y   <= sy;
      req_end_x     <= ex;
      req_end_y     <= ey;
      req_box_min_x <= mnx;
      req_box_min_y <= mny;
      req_box_max_x <= mxx;
      req_box_max_y <= mxy;
      req_last_box  <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stops offering boxes until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // The register is only written with the block idle, so a single-cycle pulse will do.
   task automatic write_clearance(input logic [CLR_BITS-1:0] value);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= value;
      cur_clearance  = value;
      @(negedge clock);
      csr_wr_en     <= 1'b0;
   endtask

   function automatic longint spread(input longint span);
      return longint'($urandom_range(32'(2 * span), 0)) - span;
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(7, 0))
         0:       return C_MIN;
         1:       return C_MAX;
         2:       return '0;
         3:       return -1;
         4:       return 1;
         5:       return FX_ONE;
         6:       return -FX_ONE;
         default: return $urandom;
      endcase
   endfunction

   // Most random boxes are well-formed geometry at a random scale near a random
   // center, so that hits, near misses and exact boundary contacts are common. The
   // rest are raw random words (mostly inverted boxes), picks from the extreme
   // values, and deliberately inverted boxes.
   task automatic send_random_box(input bit last);
      int          style;
      int          tweak;
      int unsigned reach;
      longint      cx, cy, lx, ly, hx, hy, sx, sy, ex, ey;
      style = $urandom_range(99, 0);
      tweak = $urandom_range(99, 0);
      reach = 32'd1 << $urandom_range(24, 2);
      cx = spread(longint'(1) << 29);
      cy = spread(longint'(1) << 29);
      lx = cx + spread(reach);
      ly = cy + spread(reach);
      hx = lx + longint'($urandom_range(reach, 0));
      hy = ly + longint'($urandom_range(reach, 0));
      sx = cx + spread(2 * reach);
      sy = cy + spread(2 * reach);
      ex = cx + spread(2 * reach);
      ey = cy + spread(2 * reach);
      // Degenerate and axis-parallel segments, and contacts with the grown edges.
      if (tweak < 10) begin
         ex = sx;
         ey = sy;
      end else if (tweak < 20) begin
         ex = sx;
      end else if (tweak < 30) begin
         ey = sy;
      end else if (tweak < 40) begin
         ex = lx - longint'(cur_clearance);
      end else if (tweak < 45) begin
         sx = hx + longint'(cur_clearance);
         sy = hy + longint'(cur_clearance);
      end else if (tweak < 50) begin
         ey = ly - longint'(cur_clearance);
         ex = sx;
      end
      // An inverted box on one axis or the other.
      if (style < 10) begin
         if ($urandom_range(1, 0) != 0) hx = lx - 1 - longint'($urandom_range(reach, 0));
         else hy = ly - 1 - longint'($urandom_range(reach, 0));
      end
      if (style >= 90) begin
         send_box($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, last);
      end else if (style >= 80) begin
         send_box(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                  extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(), last);
      end else begin
         send_box(coord_type'(sx), coord_type'(sy), coord_type'(ex), coord_type'(ey),
                  coord_type'(lx), coord_type'(ly), coord_type'(hx), coord_type'(hy), last);
      end
   endtask

   initial begin
      int burst;
      int gap;
      logic [CLR_BITS-1:0] phase_clearance;

      // Synchronous reset, released on a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed boxes with no clearance. Unless noted, the box is the unit square.
      write_clearance('0);
      // Horizontal crossing, both directions: entry at one half, then at one quarter.
      send_box(-2 * FX_ONE, FX_HALF, 2 * FX_ONE, FX_HALF, 0, 0, FX_ONE, FX_ONE, 1'b0);
      send_box(2 * FX_ONE, FX_HALF, -2 * FX_ONE, FX_HALF, 0, 0, FX_ONE, FX_ONE, 1'b0);
      // A line parallel to x that passes above the box.
      send_box(-2 * FX_ONE, 2 * FX_ONE, 2 * FX_ONE, 2 * FX_ONE, 0, 0, FX_ONE, FX_ONE, 1'b0);
      // Degenerate segment inside, then outside at the end of the run.
      send_box(FX_HALF, FX_HALF, FX_HALF, FX_HALF, 0, 0, FX_ONE, FX_ONE, 1'b0);
      send_box(2 * FX_ONE, 2 * FX_ONE, 2 * FX_ONE, 2 * FX_ONE, 0, 0, FX_ONE, FX_ONE, 1'b1);
      // Degenerate segment sitting exactly on a corner; the inside test is inclusive.
      send_box(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 0, 0, FX_ONE, FX_ONE, 1'b1);
      // Diagonal through the corner only: entry equals exit, which still counts.
      send_box(-FX_ONE, FX_ONE, FX_ONE, -FX_ONE, 0, 0, FX_ONE, FX_ONE, 1'b0);
      // Segment that ends on the near edge: entry time of exactly one.
      send_box(-FX_ONE, FX_HALF, 0, FX_HALF, 0, 0, FX_ONE, FX_ONE, 1'b0);
      // Vertical crossing, then a vertical miss that ends the run.
      send_box(FX_HALF, -3 * FX_ONE, FX_HALF, 3 * FX_ONE, 0, 0, FX_ONE, FX_ONE, 1'b0);
      send_box(FX_HALF, 2 * FX_ONE, FX_HALF, 5 * FX_ONE, 0, 0, FX_ONE, FX_ONE, 1'b1);
      // Box inverted in x sets any-hit for the rest of its run even though nothing hits.
      send_box(0, 0, FX_ONE, FX_ONE, FX_ONE, 0, 0, FX_ONE, 1'b0);
      send_box(3 * FX_ONE, 3 * FX_ONE, 4 * FX_ONE, 4 * FX_ONE, 0, 0, FX_ONE, FX_ONE, 1'b1);
      // Box inverted in y as a run of its own.
      send_box(0, 0, FX_ONE, FX_ONE, 0, FX_ONE, FX_ONE, 0, 1'b1);
      // Point box on the diagonal, then one that the diagonal misses by one step.
      send_box(0, 0, FX_ONE, FX_ONE, FX_HALF, FX_HALF, FX_HALF, FX_HALF, 1'b0);
      send_box(0, 0, FX_ONE, FX_ONE, FX_HALF, FX_HALF + 1, FX_HALF, FX_HALF + 1, 1'b1);
      // Full-range coordinates.
      send_box(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0);
      send_box(C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, 0, 0, 1'b0);
      send_box(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 1'b1);
      // Segment starting inside and leaving: entry time zero.
      send_box(FX_HALF, FX_HALF, 3 * FX_ONE, 3 * FX_ONE, 0, 0, FX_ONE, FX_ONE, 1'b1);

      // Widest clearance: the grown bounds go past the coordinate range.
      wait_drained();
      write_clearance(CLR_MAX);
      send_box(C_MAX, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 1'b0);
      send_box(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
      // Inversion is judged on the box as given, before the clearance is added.
      send_box(C_MIN, 0, C_MIN, 0, 1, 0, 0, 0, 1'b1);

      // Random phases. Each starts from an idle block, so the sender also waits for
      // every outstanding result at least once per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       phase_clearance = '0;
            1:       phase_clearance = CLR_BITS'(FX_ONE);
            2:       phase_clearance = CLR_MAX;
            3:       phase_clearance = CLR_BITS'(1);
            4:       phase_clearance = CLR_BITS'($urandom_range(32'h0040_0000, 0));
            5:       phase_clearance = CLR_BITS'($urandom);
            default: phase_clearance = CLR_BITS'($urandom_range(32'h0004_0000, 0));
         endcase
         wait_drained();
         write_clearance(phase_clearance);
         burst = 0;
         for (int n = 0; n < PHASE_BOXES; n++) begin
            // The sender alternates bursts of back-to-back boxes with idle gaps; now
            // and then a burst or a gap is long enough to span a whole box.
            if (burst == 0) begin
               gap = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 1) : $urandom_range(8, 1);
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
               burst = ($urandom_range(9, 0) == 0) ? $urandom_range(100, 20)
                                                   : $urandom_range(12, 1);
            end
            send_random_box($urandom_range(3, 0) == 0);
            burst--;
            if ($urandom_range(199, 0) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE_TIME) @(negedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
